[rtl/ucd_pkg.sv]
// Shared constants and the pipeline payload type for the epoch-seconds to
// civil date converter. No dependencies.
package ucd_pkg;

   // pipeline depth: one register per stage, the last one is the output register
   localparam int NUM_STAGES = 10;

   // last moment that still has a four-digit year: 9999-12-31 23:59:59
   localparam logic [37:0] LAST_SECOND = 38'd253402300799;

   // calendar constants
   localparam logic [31:0] DAY_DIVISOR  = 32'd675;       // 86400 = 675 * 128
   localparam logic [21:0] EPOCH_SHIFT  = 22'd719468;    // 0000-03-01 to 1970-01-01
   localparam logic [21:0] DAYS_PER_ERA = 22'd146097;
   localparam logic [16:0] SECS_PER_MIN = 17'd60;
   localparam logic [10:0] MINS_PER_HR  = 11'd60;
   localparam logic [17:0] DAYS_PER_YR  = 18'd365;
   localparam logic [13:0] YEARS_PER_ERA = 14'd400;

   // reciprocals for exact quotient by multiply and shift: ceil(2^S / d)
   localparam logic [31:0] DAY_RECIP    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
   localparam logic [22:0] ERA_RECIP    = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
   localparam logic [17:0] SOD60_RECIP  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
   localparam logic [11:0] MT60_RECIP   = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
   localparam logic [18:0] R1460_RECIP  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [18:0] R36524_RECIP = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
   localparam logic [18:0] R146096_RECIP = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
   localparam logic [18:0] R365_RECIP   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [9:0]  R100_RECIP   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
   localparam logic [11:0] R153_RECIP   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam logic [11:0] R5_RECIP     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

   // saturated result past the last moment
   localparam logic [13:0] SAT_YEAR   = 14'd9999;
   localparam logic [3:0]  SAT_MONTH  = 4'd12;
   localparam logic [4:0]  SAT_DAY    = 5'd31;
   localparam logic [4:0]  SAT_HOUR   = 5'd23;
   localparam logic [5:0]  SAT_MINUTE = 6'd59;
   localparam logic [5:0]  SAT_SECOND = 6'd59;

   // payload carried down the pipeline; each stage fills in a few fields
   typedef struct packed {
      logic [30:0] t_hi;      // seconds >> 7
      logic [6:0]  t_lo;      // seconds & 127
      logic        oor;       // past the last moment
      logic [21:0] qday;      // days since epoch
      logic [21:0] z;         // days since 0000-03-01
      logic [16:0] sod;       // second of day
      logic [4:0]  era;       // 400-year era
      logic [10:0] mt;        // minute of day
      logic [17:0] doe;       // day of era
      logic [5:0]  sec;
      logic [4:0]  hr;
      logic [5:0]  mnt;
      logic [6:0]  d1460;
      logic [2:0]  d36524;
      logic        d146096;
      logic [17:0] n;         // leap-corrected day of era
      logic [8:0]  yoe;       // year of era
      logic [8:0]  doy;       // day of year from March 1
      logic [3:0]  mp;        // month index from March
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  dom;
   } cvt_type;

endpackage

[rtl/ucd_flow.sv]
// Valid bits and stage enables for the converter pipeline.
// Depends on ucd_pkg (pipeline depth).
module ucd_flow import ucd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_ready,
   output logic                  in_ready,
   output logic [NUM_STAGES-1:0] stage_en,
   output logic                  out_valid
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;

   // a stage loads when it is empty or its content moves on; bubbles collapse
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[NUM_STAGES-1];

endmodule

[rtl/unix_seconds_to_civil_date_core.sv]
// Epoch seconds to Gregorian date and time, ten-stage pipeline.
// The result passes through the stage registers st_ff[0] to st_ff[9] and may wait there for
// rsp_tready; throughput one item per cycle while the output is not stalled.
// Each stage holds at most four small constant multiplies; divisions by constants
// are exact multiply-and-shift. Empty stages fill while the output waits.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
module unix_seconds_to_civil_date_core import ucd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [37:0] epoch_seconds, [39:38] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [13:0] year, [17:14] month, [22:18] day,
                                    // [27:23] hour, [33:28] minute, [39:34] second
   output logic        rsp_tuser    // [0] out_of_range
);

   logic [NUM_STAGES-1:0] stage_en;
   cvt_type               st_ff [NUM_STAGES];
   cvt_type               st_in [NUM_STAGES];

   ucd_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .stage_en  (stage_en),
      .out_valid (rsp_tvalid)
   );

   // stage logic, one section per register stage
   always_comb begin
      logic [62:0] day_prod;
      logic [31:0] day_back;
      logic [44:0] era_prod;
      logic [34:0] mt_prod;
      logic [22:0] hr_prod;
      logic [36:0] p1460;
      logic [36:0] p36524;
      logic [36:0] p146096;
      logic [36:0] p365;
      logic [18:0] p100;
      logic [17:0] yoe_days;
      logic [10:0] mp_num;
      logic [22:0] p153;
      logic [10:0] dm_num;
      logic [22:0] p5;
      logic [8:0]  dm_off;
      logic [3:0]  mon;

      // days since epoch: seconds / 86400 as (seconds >> 7) / 675
      st_in[0]      = '0;
      st_in[0].t_hi = req_tdata[37:7];
      st_in[0].t_lo = req_tdata[6:0];
      st_in[0].oor  = req_tdata[37:0] > LAST_SECOND;
      day_prod      = 63'(req_tdata[37:7]) * 63'(DAY_RECIP);
      st_in[0].qday = day_prod[62:41];

      // second of day and day number from 0000-03-01
      st_in[1]     = st_ff[0];
      day_back     = 32'(st_ff[0].qday) * DAY_DIVISOR;
      st_in[1].sod = {10'(st_ff[0].t_hi - day_back[30:0]), st_ff[0].t_lo};
      st_in[1].z   = st_ff[0].qday + EPOCH_SHIFT;

      // era and minute of day
      st_in[2]     = st_ff[1];
      era_prod     = 45'(st_ff[1].z) * 45'(ERA_RECIP);
      st_in[2].era = era_prod[44:40];
      mt_prod      = 35'(st_ff[1].sod) * 35'(SOD60_RECIP);
      st_in[2].mt  = mt_prod[33:23];

      // day of era, second, hour
      st_in[3]     = st_ff[2];
      st_in[3].doe = 18'(st_ff[2].z - 22'(st_ff[2].era) * DAYS_PER_ERA);
      st_in[3].sec = 6'(st_ff[2].sod - 17'(st_ff[2].mt) * SECS_PER_MIN);
      hr_prod      = 23'(st_ff[2].mt) * 23'(MT60_RECIP);
      st_in[3].hr  = hr_prod[21:17];

      // leap corrections within the era, minute
      st_in[4]         = st_ff[3];
      p1460            = 37'(st_ff[3].doe) * 37'(R1460_RECIP);
      p36524           = 37'(st_ff[3].doe) * 37'(R36524_RECIP);
      p146096          = 37'(st_ff[3].doe) * 37'(R146096_RECIP);
      st_in[4].d1460   = p1460[35:29];
      st_in[4].d36524  = p36524[36:34];
      st_in[4].d146096 = p146096[36];
      st_in[4].mnt     = 6'(st_ff[3].mt - 11'(st_ff[3].hr) * MINS_PER_HR);

      // corrected day count
      st_in[5]   = st_ff[4];
      st_in[5].n = st_ff[4].doe - 18'(st_ff[4].d1460) + 18'(st_ff[4].d36524)
                 - 18'(st_ff[4].d146096);

      // year of era
      st_in[6]     = st_ff[5];
      p365         = 37'(st_ff[5].n) * 37'(R365_RECIP);
      st_in[6].yoe = p365[35:27];

      // day of year, counted from March 1
      st_in[7]     = st_ff[6];
      p100         = 19'(st_ff[6].yoe) * 19'(R100_RECIP);
      yoe_days     = 18'(st_ff[6].yoe) * DAYS_PER_YR + 18'(st_ff[6].yoe[8:2])
                   - 18'(p100[17:16]);
      st_in[7].doy = 9'(st_ff[6].doe - yoe_days);

      // month index from March
      st_in[8]    = st_ff[7];
      mp_num      = 11'(st_ff[7].doy) * 11'd5 + 11'd2;
      p153        = 23'(mp_num) * 23'(R153_RECIP);
      st_in[8].mp = p153[22:19];

      // day of month, calendar month, year; saturate past the last moment
      st_in[9] = st_ff[8];
      dm_num   = 11'(st_ff[8].mp) * 11'd153 + 11'd2;
      p5       = 23'(dm_num) * 23'(R5_RECIP);
      dm_off   = p5[22:14];
      // March..December map to 3..12, January and February to 1..2
      mon      = (st_ff[8].mp < 4'd10) ? st_ff[8].mp + 4'd3 : st_ff[8].mp - 4'd9;
      if (st_ff[8].oor) begin
         st_in[9].year  = SAT_YEAR;
         st_in[9].month = SAT_MONTH;
         st_in[9].dom   = SAT_DAY;
         st_in[9].hr    = SAT_HOUR;
         st_in[9].mnt   = SAT_MINUTE;
         st_in[9].sec   = SAT_SECOND;
      end else begin
         st_in[9].dom   = 5'(st_ff[8].doy - dm_off + 9'd1);
         st_in[9].month = mon;
         st_in[9].year  = 14'(st_ff[8].yoe) + 14'(st_ff[8].era) * YEARS_PER_ERA
                        + ((mon <= 4'd2) ? 14'd1 : 14'd0);
      end
   end

   // stage registers, loaded under the flow control enables
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // result transfer
   assign rsp_tdata = {st_ff[NUM_STAGES-1].sec, st_ff[NUM_STAGES-1].mnt,
                       st_ff[NUM_STAGES-1].hr, st_ff[NUM_STAGES-1].dom,
                       st_ff[NUM_STAGES-1].month, st_ff[NUM_STAGES-1].year};
   assign rsp_tuser = st_ff[NUM_STAGES-1].oor;

endmodule
